// ===== design/cmsk_pkg.sv =====
// Package for the C comment and literal masker: codes, characters, result type.
package cmsk_pkg;

  localparam int unsigned ChW = 8;

  localparam logic [ChW-1:0] ChSlash  = 8'h2F;
  localparam logic [ChW-1:0] ChStar   = 8'h2A;
  localparam logic [ChW-1:0] ChDquote = 8'h22;
  localparam logic [ChW-1:0] ChSquote = 8'h27;
  localparam logic [ChW-1:0] ChBslash = 8'h5C;
  localparam logic [ChW-1:0] ChNl     = 8'h0A;
  localparam logic [ChW-1:0] ChSpace  = 8'h20;

  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_LINE  = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_STR   = 3'd3,
    MODE_CHR   = 3'd4
  } mode_e;

  // Bytes produced by one input transaction, oldest in b0.
  typedef struct packed {
    logic [1:0]     cnt;
    logic [ChW-1:0] b0;
    logic [ChW-1:0] b1;
    logic           last;
  } res_t;

  // Append one byte to a result; extra bytes beyond two are dropped.
  function automatic res_t push(res_t r, logic [ChW-1:0] c);
    res_t o;
    o = r;
    if (r.cnt == 2'd0) begin
      o.b0  = c;
      o.cnt = 2'd1;
    end else if (r.cnt == 2'd1) begin
      o.b1  = c;
      o.cnt = 2'd2;
    end
    return o;
  endfunction

  function automatic logic [ChW-1:0] mask_nl(logic [ChW-1:0] c);
    return (c == ChNl) ? ChNl : ChSpace;
  endfunction

endpackage

// ===== design/c_comment_string_masker_top.sv =====
// C comment and literal masker, top level: input register, core, result register.
// An input transaction reaches its first output byte through the input register, then the
//   result register.
// Throughput: one byte per cycle while the output is not stalled; a byte that yields two output
//   bytes stalls the input while the result register drains its second byte.
// Reset (rst_ni, async, active low): code mode, no escape, nothing held, both registers empty.
module c_comment_string_masker_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [cmsk_pkg::ChW-1:0]  ch_i,
  input  logic                      is_last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cmsk_pkg::ChW-1:0]  out_ch_o,
  output logic                      out_last_o
);

  // Input register
  logic                     in_valid_q;
  logic [cmsk_pkg::ChW-1:0] in_ch_q;
  logic                     in_last_q;

  logic           obuf_ready;
  logic           step;
  cmsk_pkg::res_t res;

  // The held byte advances whenever the result register has room for its bytes.
  assign step       = in_valid_q && obuf_ready;
  assign in_stall_o = in_valid_q && !obuf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_ch_q   <= ch_i;
      in_last_q <= is_last_i;
    end
  end

  // Masking state machine plus combinational byte decode
  cmsk_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .ch_i      (in_ch_q),
    .is_last_i (in_last_q),
    .res_o     (res)
  );

  // Result register, serializes zero to two bytes per transaction
  cmsk_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .ready_o     (obuf_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_ch_o    (out_ch_o),
    .out_last_o  (out_last_o)
  );

  // Stall toward the source only comes from a full input register.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stall without a pending byte");

  // An empty result register always takes the pending byte.
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while result register empty");

  // A pending byte that cannot advance is kept unchanged.
  a_pending_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_stall_o) |=> (in_valid_q && $stable(in_ch_q) && $stable(in_last_q)))
    else $error("pending byte lost while stalled");

endmodule

// ===== design/cmsk_core.sv =====
// Masking state and the per-byte next-state / output logic.
module cmsk_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [cmsk_pkg::ChW-1:0]  ch_i,
  input  logic                      is_last_i,
  output cmsk_pkg::res_t            res_o
);

  cmsk_pkg::mode_e mode_q, mode_d;
  logic            esc_q, esc_d;
  logic            held_q, held_d;

  always_comb begin
    cmsk_pkg::res_t r;
    logic           do_code;
    logic           do_block;
    r        = '0;
    mode_d   = mode_q;
    esc_d    = esc_q;
    held_d   = held_q;
    do_code  = 1'b0;
    do_block = 1'b0;

    unique case (mode_q) inside
      cmsk_pkg::MODE_LINE: begin
        if (ch_i == cmsk_pkg::ChNl) begin
          r      = cmsk_pkg::push(r, cmsk_pkg::ChNl);
          mode_d = cmsk_pkg::MODE_CODE;
        end else begin
          r = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
        end
      end
      cmsk_pkg::MODE_BLOCK: begin
        if (held_q) begin
          held_d = 1'b0;
          if (ch_i == cmsk_pkg::ChSlash) begin
            r      = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
            r      = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
            mode_d = cmsk_pkg::MODE_CODE;
          end else begin
            // held star was not a terminator
            r        = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
            do_block = 1'b1;
          end
        end else begin
          do_block = 1'b1;
        end
      end
      cmsk_pkg::MODE_STR, cmsk_pkg::MODE_CHR: begin
        r = cmsk_pkg::push(r, cmsk_pkg::mask_nl(ch_i));
        if (!esc_q && ch_i == ((mode_q == cmsk_pkg::MODE_STR) ?
                               cmsk_pkg::ChDquote : cmsk_pkg::ChSquote)) begin
          mode_d = cmsk_pkg::MODE_CODE;
        end
        esc_d = !esc_q && (ch_i == cmsk_pkg::ChBslash);
      end
      default: begin
        if (held_q) begin
          held_d = 1'b0;
          if (ch_i == cmsk_pkg::ChSlash) begin
            r      = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
            r      = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
            mode_d = cmsk_pkg::MODE_LINE;
          end else if (ch_i == cmsk_pkg::ChStar) begin
            r      = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
            r      = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
            mode_d = cmsk_pkg::MODE_BLOCK;
          end else begin
            // lone slash goes out as is
            r       = cmsk_pkg::push(r, cmsk_pkg::ChSlash);
            do_code = 1'b1;
          end
        end else begin
          do_code = 1'b1;
        end
      end
    endcase

    if (do_code) begin
      if (ch_i == cmsk_pkg::ChSlash) begin
        held_d = 1'b1;
      end else if (ch_i == cmsk_pkg::ChDquote) begin
        r      = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
        mode_d = cmsk_pkg::MODE_STR;
        esc_d  = 1'b0;
      end else if (ch_i == cmsk_pkg::ChSquote) begin
        r      = cmsk_pkg::push(r, cmsk_pkg::ChSpace);
        mode_d = cmsk_pkg::MODE_CHR;
        esc_d  = 1'b0;
      end else begin
        r = cmsk_pkg::push(r, ch_i);
      end
    end

    if (do_block) begin
      if (ch_i == cmsk_pkg::ChStar) begin
        held_d = 1'b1;
      end else begin
        r = cmsk_pkg::push(r, cmsk_pkg::mask_nl(ch_i));
      end
    end

    // end of stream: flush held byte, back to reset state
    if (is_last_i) begin
      if (held_d) begin
        r = cmsk_pkg::push(r, (mode_d == cmsk_pkg::MODE_CODE) ?
                              cmsk_pkg::ChSlash : cmsk_pkg::ChSpace);
      end
      r.last = 1'b1;
      mode_d = cmsk_pkg::MODE_CODE;
      esc_d  = 1'b0;
      held_d = 1'b0;
    end

    res_o = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cmsk_pkg::MODE_CODE;
      esc_q  <= 1'b0;
      held_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      held_q <= held_d;
    end
  end

endmodule

// ===== design/cmsk_obuf.sv =====
// Result register: holds up to two output bytes and hands them out one by one.
module cmsk_obuf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  cmsk_pkg::res_t            res_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cmsk_pkg::ChW-1:0]  out_ch_o,
  output logic                      out_last_o
);

  logic [1:0]               cnt_q;
  logic [cmsk_pkg::ChW-1:0] b0_q, b1_q;
  logic                     last_q;
  logic                     pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_ch_o    = b0_q;
  assign out_last_o  = last_q && (cnt_q == 2'd1);
  assign pop         = out_valid_o && !out_stall_i;
  // free after this cycle
  assign ready_o     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      b0_q   <= res_i.b0;
      b1_q   <= res_i.b1;
      last_q <= res_i.last;
    end else if (pop) begin
      b0_q <= b1_q;
    end
  end

endmodule
